// ----- rtl/pidl_pkg.sv -----
`default_nettype none

package pidl_pkg;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_DUMP   = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_INVALID = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_EMPTY   = 3'd3,
      STATUS_ENTRY   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_value;
      logic [5:0]  entry_index;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_DUMP = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic dump_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       list_empty;
      logic       dump_last;
      logic       slot_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/positional_insert_delete_list.sv -----
`default_nettype none

// Ordered list of up to DEPTH words held in a row of register cells, position
// 0 at the bottom. Insert and delete move every affected cell at once
// through the neighbour shift network. An insert, a delete or a dump of an
// empty list is taken in S_IDLE and executed in S_EXEC, which loads the
// single result; an ignored action code is executed with no result. A dump
// of a non-empty list then streams from S_DUMP, one result per cycle while
// rsp_ready stays high, as the stored entries rotate past the bottom cell.
// Execute and dump steps wait while rsp_ready low holds the result. A new item
// may be taken while the previous result still waits. Cells are not cleared
// at reset, only the count, dump index and valid flag: no clearing pass.

module positional_insert_delete_list #(
   parameter int DEPTH      = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pidl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pidl_pkg::rsp_type      rsp_data
);

   pidl_pkg::cmd_type  cmd;
   pidl_pkg::stat_type stat;

   pidl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pidl_datapath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/pidl_ctrl.sv -----
`default_nettype none

module pidl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pidl_pkg::stat_type stat,
   output pidl_pkg::cmd_type       cmd
);

   pidl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidl_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pidl_pkg::S_EXEC;
            end
         end
         pidl_pkg::S_EXEC: begin
            if (stat.slot_free) begin
               if (stat.action == pidl_pkg::ACT_DUMP && !stat.list_empty) begin
                  state_in = pidl_pkg::S_DUMP;
               end else begin
                  state_in = pidl_pkg::S_IDLE;
               end
            end
         end
         pidl_pkg::S_DUMP: begin
            if (stat.slot_free && stat.dump_last) begin
               state_in = pidl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pidl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      cmd.dump_step = 1'b0;
      case (state_ff)
         pidl_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pidl_pkg::S_EXEC: begin
            cmd.execute = stat.slot_free;
         end
         pidl_pkg::S_DUMP: begin
            cmd.dump_step = stat.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/pidl_datapath.sv -----
`default_nettype none

module pidl_datapath #(
   parameter int DEPTH      = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pidl_pkg::req_type req_data,
   input  wire pidl_pkg::cmd_type cmd,
   output pidl_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pidl_pkg::rsp_type      rsp_data
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

   logic [VALUE_BITS-1:0] cell_ff  [DEPTH];
   logic [VALUE_BITS-1:0] cell_in  [DEPTH];
   logic [VALUE_BITS-1:0] up_src   [DEPTH];
   logic [VALUE_BITS-1:0] down_src [DEPTH];

   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     dump_idx_ff, dump_idx_in;
   pidl_pkg::req_type req_ff;
   pidl_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CMPW-1:0]       pos_c, cnt_c;
   logic [VALUE_BITS-1:0] new_value;
   logic                  ins_bad, del_bad, list_full, list_empty, dump_last, slot_free;

   assign pos_c      = CMPW'(req_ff.position);
   assign cnt_c      = CMPW'(count_ff);
   assign new_value  = VALUE_BITS'(req_ff.value);
   assign ins_bad    = pos_c > cnt_c;
   assign del_bad    = pos_c >= cnt_c;
   assign list_full  = count_ff == CW'(DEPTH);
   assign list_empty = count_ff == '0;
   assign dump_last  = (CMPW'(dump_idx_ff) + CMPW'(1)) == cnt_c;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Each cell sees only its neighbours; the bottom cell takes the new value
   // from below and the top cell holds itself from above.
   for (genvar g = 0; g < DEPTH; g++) begin : g_src
      if (g == 0) begin : g_bottom
         assign up_src[g] = new_value;
      end else begin : g_up
         assign up_src[g] = cell_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_top
         assign down_src[g] = cell_ff[g];
      end else begin : g_down
         assign down_src[g] = cell_ff[g+1];
      end
   end

   always_comb begin
      cell_in      = cell_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.execute) begin
         dump_idx_in        = '0;
         rsp_in.status      = pidl_pkg::STATUS_OK;
         rsp_in.entry_value = '0;
         rsp_in.entry_index = '0;
         rsp_in.last        = 1'b1;
         case (req_ff.action)
            pidl_pkg::ACT_INSERT: begin
               rsp_valid_in = 1'b1;
               if (ins_bad) begin
                  rsp_in.status = pidl_pkg::STATUS_INVALID;
               end else if (list_full) begin
                  rsp_in.status = pidl_pkg::STATUS_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMPW'(i) > pos_c && CMPW'(i) <= cnt_c) begin
                        cell_in[i] = up_src[i];
                     end else if (CMPW'(i) == pos_c) begin
                        cell_in[i] = new_value;
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            pidl_pkg::ACT_DELETE: begin
               rsp_valid_in = 1'b1;
               if (del_bad) begin
                  rsp_in.status = pidl_pkg::STATUS_INVALID;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMPW'(i) >= pos_c && (CMPW'(i) + CMPW'(1)) < cnt_c) begin
                        cell_in[i] = down_src[i];
                     end
                  end
                  count_in = count_ff - CW'(1);
               end
            end
            pidl_pkg::ACT_DUMP: begin
               // A non-empty list is streamed by the dump steps that follow.
               if (list_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = pidl_pkg::STATUS_EMPTY;
               end
            end
            default: begin
               rsp_in = rsp_ff;
            end
         endcase
      end

      if (cmd.dump_step) begin
         // The stored part of the list rotates down by one each step, so the
         // bottom cell always holds the next entry and the list is whole again
         // after the final step.
         rsp_valid_in       = 1'b1;
         rsp_in.status      = pidl_pkg::STATUS_ENTRY;
         rsp_in.entry_value = 32'(cell_ff[0]);
         rsp_in.entry_index = 6'(dump_idx_ff);
         rsp_in.last        = dump_last;
         for (int i = 0; i < DEPTH; i++) begin
            if ((CMPW'(i) + CMPW'(1)) < cnt_c) begin
               cell_in[i] = down_src[i];
            end else if ((CMPW'(i) + CMPW'(1)) == cnt_c) begin
               cell_in[i] = cell_ff[0];
            end
         end
         dump_idx_in = dump_idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   assign stat.action     = req_ff.action;
   assign stat.list_empty = list_empty;
   assign stat.dump_last  = dump_last;
   assign stat.slot_free  = slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/pidl_checker.sv -----
`default_nettype none

module pidl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pidl_pkg::rsp_type rsp_data
);

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   // A result held back by the consumer must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An item is never taken in the cycle straight after another one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_ready)
      else $error("item taken while the previous one is executing");

   // Within a dump, the next entry is ready as soon as the previous one is taken.
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last
      |=> rsp_valid && rsp_data.status == pidl_pkg::STATUS_ENTRY)
      else $error("dump stream broken");

   // Dumped entries count up from the bottom of the list.
   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last
      |=> rsp_data.entry_index == 6'($past(rsp_data.entry_index) + 6'd1))
      else $error("dump index out of sequence");

   // Only dumped entries carry a value or an index.
   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pidl_pkg::STATUS_ENTRY
      |-> rsp_data.entry_value == '0 && rsp_data.entry_index == '0 && rsp_data.last)
      else $error("status result with stray fields");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (.*);

`default_nettype wire
